[design/tvefr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the triple-vote escaped frame receiver.
// No dependencies; imported by every module of the block.
package tvefr_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 6;
  localparam int IDX_W  = 2;

  typedef logic [BYTE_W-1:0] byte_t;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_ESCAPE = 2'd0,
    REG_START  = 2'd1,
    REG_STOP   = 2'd2
  } reg_idx_t;

  localparam byte_t ESCAPE_RST = 8'h11;
  localparam byte_t START_RST  = 8'h21;
  localparam byte_t STOP_RST   = 8'h31;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  typedef struct packed {
    byte_t escape_code;
    byte_t start_code;
    byte_t stop_code;
  } codes_t;

  // one resolved symbol from the vote window
  typedef struct packed {
    logic  valid;
    byte_t value;
  } sym_t;

  typedef struct packed {
    logic             valid;
    logic             kind;
    byte_t            data;
    logic [POS_W-1:0] position;
    logic             overflow;
  } res_t;

endpackage

[design/tvefr_vote.sv]
`timescale 1ns / 1ps
// Three-byte vote window: collects raw bytes and resolves at most one symbol per full window.
// Depends on tvefr_pkg.
module tvefr_vote
  import tvefr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step,
  input  byte_t rx_byte,
  input  logic  in_message,
  output sym_t  sym
);

  byte_t      w0_r, w1_r, w0_nxt, w1_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       ok;
  byte_t      value;

  always_comb begin
    ok    = 1'b0;
    value = w0_r;
    if (in_message) begin
      // two of three: oldest byte wins ties
      if (w0_r == w1_r || w0_r == rx_byte) begin
        ok    = 1'b1;
        value = w0_r;
      end else if (w1_r == rx_byte) begin
        ok    = 1'b1;
        value = w1_r;
      end
    end else begin
      ok = (w0_r == w1_r) && (w0_r == rx_byte);
    end
  end

  always_comb begin
    w0_nxt    = w0_r;
    w1_nxt    = w1_r;
    fill_nxt  = fill_r;
    sym.valid = 1'b0;
    sym.value = value;
    if (step) begin
      case (fill_r)
        2'd0: begin
          w0_nxt   = rx_byte;
          fill_nxt = 2'd1;
        end
        2'd1: begin
          w1_nxt   = rx_byte;
          fill_nxt = 2'd2;
        end
        default: begin
          if (ok) begin
            sym.valid = 1'b1;
            fill_nxt  = 2'd0;
          end else begin
            // slide by one byte
            w0_nxt   = w1_r;
            w1_nxt   = rx_byte;
            fill_nxt = 2'd2;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w0_r <= w0_nxt;
    w1_r <= w1_nxt;
  end

endmodule

[design/tvefr_deframer.sv]
`timescale 1ns / 1ps
// Framing state machine: start/escape/stop handling, payload positions, overflow.
// Depends on tvefr_pkg.
module tvefr_deframer
  import tvefr_pkg::*;
#(
  parameter int MAX_MESSAGE = 32
) (
  input  logic   clk,
  input  logic   rst_n,
  input  sym_t   sym,
  input  codes_t codes,
  output logic   in_message,
  output res_t   res
);

  localparam int LEN_W = $clog2(MAX_MESSAGE + 1);
  localparam int EXT_W = (LEN_W > POS_W) ? LEN_W : POS_W;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_MESSAGE);

  logic             in_msg_r, in_msg_nxt;
  logic             esc_r, esc_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             exc_r, exc_nxt;
  logic [EXT_W-1:0] len_ext;
  logic             store;

  assign in_message = in_msg_r;
  assign len_ext    = EXT_W'(len_r);

  always_comb begin
    in_msg_nxt   = in_msg_r;
    esc_nxt      = esc_r;
    len_nxt      = len_r;
    exc_nxt      = exc_r;
    store        = 1'b0;
    res.valid    = 1'b0;
    res.kind     = KIND_PAYLOAD;
    res.data     = sym.value;
    res.position = len_ext[POS_W-1:0];
    res.overflow = 1'b0;
    if (sym.valid) begin
      if (in_msg_r) begin
        if (esc_r) begin
          esc_nxt = 1'b0;
          store   = 1'b1;
        end else if (sym.value == codes.escape_code) begin
          esc_nxt = 1'b1;
        end else if (sym.value == codes.stop_code) begin
          in_msg_nxt   = 1'b0;
          res.valid    = 1'b1;
          res.kind     = KIND_END;
          res.data     = '0;
          res.overflow = exc_r;
        end else begin
          store = 1'b1;
        end
      end else if (sym.value == codes.start_code) begin
        in_msg_nxt = 1'b1;
        esc_nxt    = 1'b0;
        len_nxt    = '0;
        exc_nxt    = 1'b0;
      end
    end
    if (store) begin
      if (len_r < LEN_MAX) begin
        res.valid = 1'b1;
        len_nxt   = len_r + 1'b1;
      end else begin
        exc_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r <= 1'b0;
      esc_r    <= 1'b0;
      len_r    <= '0;
      exc_r    <= 1'b0;
    end else begin
      in_msg_r <= in_msg_nxt;
      esc_r    <= esc_nxt;
      len_r    <= len_nxt;
      exc_r    <= exc_nxt;
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_MAX) else $error("message length beyond capacity");

  a_exc_full: assert property (@(posedge clk) disable iff (!rst_n)
    exc_r |-> len_r == LEN_MAX) else $error("overflow flagged before capacity reached");

  a_esc_in_msg: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> in_msg_r) else $error("escape pending outside a message");

endmodule

[design/triple_vote_escaped_frame_receiver.sv]
`timescale 1ns / 1ps
// A byte accepted into the input register has its result, if any, registered into the result register when it steps.
// Throughput: one byte per cycle while no result stalls; the input register and result register each hold one beat.
// A stalled result backs up into the input register, then in_stall rises.
// Reset (synchronous, rst_n low): window empty, idle, codes back to 0x11/0x21/0x31.
// Depends on tvefr_pkg, tvefr_vote and tvefr_deframer.
module triple_vote_escaped_frame_receiver
  import tvefr_pkg::*;
#(
  parameter int MAX_MESSAGE = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  byte_t            in_rx_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_kind,
  output byte_t            out_data,
  output logic [POS_W-1:0] out_position,
  output logic             out_overflow,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  byte_t            cfg_data
);

  codes_t codes_r, codes_nxt;
  logic   s1_valid_r, s1_valid_nxt;
  byte_t  s1_byte_r, s1_byte_nxt;
  res_t   out_r, out_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   adv, step, in_message;
  sym_t   sym;
  res_t   res;

  assign cfg_ready = 1'b1;

  always_comb begin
    codes_nxt = codes_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ESCAPE: codes_nxt.escape_code = cfg_data;
        REG_START:  codes_nxt.start_code  = cfg_data;
        REG_STOP:   codes_nxt.stop_code   = cfg_data;
        default:    codes_nxt = codes_r;
      endcase
    end
  end

  // result register free or draining this cycle
  assign adv      = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_byte_nxt  = s1_byte_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
      if (in_valid) begin
        s1_byte_nxt = in_rx_byte;
      end
    end
  end

  tvefr_vote u_vote (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .rx_byte    (s1_byte_r),
    .in_message (in_message),
    .sym        (sym)
  );

  tvefr_deframer #(
    .MAX_MESSAGE (MAX_MESSAGE)
  ) u_deframer (
    .clk        (clk),
    .rst_n      (rst_n),
    .sym        (sym),
    .codes      (codes_r),
    .in_message (in_message),
    .res        (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (adv) begin
      out_valid_nxt = step && res.valid;
      if (step && res.valid) begin
        out_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r.escape_code <= ESCAPE_RST;
      codes_r.start_code  <= START_RST;
      codes_r.stop_code   <= STOP_RST;
      s1_valid_r          <= 1'b0;
      out_valid_r         <= 1'b0;
    end else begin
      codes_r     <= codes_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_byte_r <= s1_byte_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_r.kind;
  assign out_data     = out_r.data;
  assign out_position = out_r.position;
  assign out_overflow = out_r.overflow;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && out_stall) else $error("input stalled with free result register");

  a_payload_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.kind == KIND_PAYLOAD |-> !out_r.overflow)
    else $error("overflow flag on a payload beat");

  a_end_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.kind == KIND_END |-> out_r.data == '0)
    else $error("end beat carries nonzero data");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !s1_valid_r) else $error("pipeline not empty after reset");

endmodule
